// File: src/ccirc_pkg.sv
// shared constants for the triangle circumcircle pipeline
`timescale 1ns / 1ps
`default_nettype none

package ccirc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  // quotient bits kept by the divider; larger quotients always saturate
  localparam int QUOT_BITS = 45;
  localparam int DIV_LAT   = QUOT_BITS + 2;

  localparam int ROOT_W = 32;
  localparam int SQ_LAT = ROOT_W;

  localparam int FRONT_LAT = 7;

  localparam int OUT_W    = 32;
  localparam int ORIENT_W = 36;
  localparam int OUT_DATA_W = ((3 * OUT_W + ORIENT_W + 7) / 8) * 8;

  localparam int USER_DEG = 0;
  localparam int USER_SAT = 1;

endpackage

`default_nettype wire

// File: src/ccirc_div.sv
// pipelined restoring divider, one quotient bit per stage, rounds half up
`timescale 1ns / 1ps
`default_nettype none

module ccirc_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 35
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [NUM_W-1:0]              num,
  input  logic [DEN_W-1:0]              den,
  output logic [ccirc_pkg::QUOT_BITS:0] quot,
  output logic                          ovf
);
  import ccirc_pkg::*;

  localparam int CMP_W = (NUM_W > DEN_W + QUOT_BITS) ? NUM_W : DEN_W + QUOT_BITS;

  logic [CMP_W-1:0] num_w;
  logic [CMP_W-1:0] den_w;
  logic [CMP_W-1:0] hi_w;

  assign num_w = CMP_W'(num);
  assign den_w = CMP_W'(den) << QUOT_BITS;
  assign hi_w  = num_w >> QUOT_BITS;

  logic [DEN_W-1:0]     rem_p_r;
  logic [QUOT_BITS-1:0] nl_p_r;
  logic [DEN_W-1:0]     dn_p_r;
  logic                 of_p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_p_r <= hi_w[DEN_W-1:0];
      nl_p_r  <= num_w[QUOT_BITS-1:0];
      dn_p_r  <= den;
      of_p_r  <= (num_w >= den_w);
    end
  end

  logic [DEN_W-1:0]     rem_r [QUOT_BITS];
  logic [QUOT_BITS-1:0] nl_r  [QUOT_BITS];
  logic [QUOT_BITS-1:0] q_r   [QUOT_BITS];
  logic [DEN_W-1:0]     dn_r  [QUOT_BITS];
  logic                 of_r  [QUOT_BITS];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
    logic [DEN_W-1:0]     rem_i;
    logic [QUOT_BITS-1:0] nl_i;
    logic [QUOT_BITS-1:0] q_i;
    logic [DEN_W-1:0]     dn_i;
    logic                 of_i;
    logic [DEN_W:0]       trial;
    logic                 fit;

    if (k == 0) begin : g_first
      assign rem_i = rem_p_r;
      assign nl_i  = nl_p_r;
      assign q_i   = '0;
      assign dn_i  = dn_p_r;
      assign of_i  = of_p_r;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign nl_i  = nl_r[k-1];
      assign q_i   = q_r[k-1];
      assign dn_i  = dn_r[k-1];
      assign of_i  = of_r[k-1];
    end

    assign trial = {rem_i, nl_i[QUOT_BITS-1-k]};
    assign fit   = (trial >= {1'b0, dn_i});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fit ? DEN_W'(trial - {1'b0, dn_i}) : trial[DEN_W-1:0];
        nl_r[k]  <= nl_i;
        q_r[k]   <= {q_i[QUOT_BITS-2:0], fit};
        dn_r[k]  <= dn_i;
        of_r[k]  <= of_i;
      end
    end
  end

  logic rnd;
  assign rnd = ({rem_r[QUOT_BITS-1], 1'b0} >= {1'b0, dn_r[QUOT_BITS-1]});

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= (QUOT_BITS + 1)'(q_r[QUOT_BITS-1]) + (QUOT_BITS + 1)'(rnd);
      ovf  <= of_r[QUOT_BITS-1];
    end
  end

endmodule

`default_nettype wire

// File: src/ccirc_isqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none

module ccirc_isqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [2*ccirc_pkg::ROOT_W-1:0]   sq,
  output logic [ccirc_pkg::ROOT_W-1:0]     root
);
  import ccirc_pkg::*;

  logic [ROOT_W+1:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0]   rt_r   [ROOT_W];
  logic [2*ROOT_W-1:0] sq_r   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [ROOT_W+1:0]   rem_i;
    logic [ROOT_W-1:0]   rt_i;
    logic [2*ROOT_W-1:0] sq_i;
    logic [ROOT_W+1:0]   cur;
    logic [ROOT_W+1:0]   trial;
    logic                fit;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign rt_i  = '0;
      assign sq_i  = sq;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign rt_i  = rt_r[k-1];
      assign sq_i  = sq_r[k-1];
    end

    assign cur   = {rem_i[ROOT_W-1:0], sq_i[2*(ROOT_W-1-k)+1 -: 2]};
    assign trial = {rt_i, 2'b01};
    assign fit   = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fit ? (cur - trial) : cur;
        rt_r[k]  <= {rt_i[ROOT_W-2:0], fit};
        sq_r[k]  <= sq_i;
      end
    end
  end

  assign root = rt_r[ROOT_W-1];

endmodule

`default_nettype wire

// File: src/triangle_circumcircle.sv
// top level: circumcircle center, radius and orientation of a 2d triangle
//
//  channel | dir | beat contents
//  in_     | in  | tdata: ax, ay, bx, by_coord, cx, cy
//  out_    | out | tdata: ctr_x, ctr_y, radius, orientation
//          |     | tuser: degenerate, saturated
//
//  one beat per cycle in while no result beat is stalled
//  latency is set mostly by the divider and square root stages, one result bit per stage
//  rst_n clears only the valid bits of the pipeline
//  a stalled result beat freezes the whole pipeline; in_tready follows it
`timescale 1ns / 1ps
`default_nettype none

module triangle_circumcircle #(
  parameter int COORD_WIDTH = ccirc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ccirc_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // ax, ay, bx, by_coord, cx, cy
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // ctr_x, ctr_y, radius, orientation
  output logic [ccirc_pkg::OUT_DATA_W-1:0] out_tdata,
  // degenerate, saturated
  output logic [1:0] out_tuser
);
  import ccirc_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DFW  = CW + 1;
  localparam int PW   = 2 * CW + 2;
  localparam int SQW  = 2 * CW + 1;
  localparam int DW   = 2 * CW + 3;
  localparam int LW   = 2 * CW + 2;
  localparam int LH   = CW + 1;
  localparam int PPW  = 2 * CW + 3;
  localparam int PAW  = 3 * CW + 3;
  localparam int UW   = 3 * CW + 4;
  localparam int NW   = UW + FRAC_BITS;
  localparam int EW   = (DW > ORIENT_W) ? DW : ORIENT_W;
  localparam int VW   = ((CW + FRAC_BITS > QUOT_BITS) ? CW + FRAC_BITS : QUOT_BITS) + 1;
  localparam int PIPE = FRONT_LAT + DIV_LAT + 2 + SQ_LAT + 1;

  localparam logic signed [EW-1:0] OMAX = EW'(64'sd34359738367);
  localparam logic signed [EW-1:0] OMIN = EW'(-64'sd34359738368);
  localparam logic signed [VW-1:0] CMAX = VW'(64'sd2147483647);
  localparam logic signed [VW-1:0] CMIN = VW'(-64'sd2147483648);

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic                 negx;
    logic                 negy;
    logic [ORIENT_W-1:0]  orient;
    logic                 deg;
  } side_t;

  typedef struct packed {
    logic [OUT_W-1:0]    ctr_x;
    logic [OUT_W-1:0]    ctr_y;
    logic                csat;
    logic                rsat;
    logic [ORIENT_W-1:0] orient;
    logic                deg;
  } tail_t;

  logic en;
  logic [PIPE-1:0] v_r;

  assign en        = !v_r[PIPE-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = v_r[PIPE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[PIPE-2:0], in_tvalid};
    end
  end

  logic signed [CW-1:0] ax, ay, bx, by_coord, cx, cy;
  assign ax       = in_tdata[0*CW +: CW];
  assign ay       = in_tdata[1*CW +: CW];
  assign bx       = in_tdata[2*CW +: CW];
  assign by_coord = in_tdata[3*CW +: CW];
  assign cx       = in_tdata[4*CW +: CW];
  assign cy       = in_tdata[5*CW +: CW];

  // stage 1: differences to vertex c
  logic signed [DFW-1:0] dxa1_r, dya1_r, dxb1_r, dyb1_r;
  logic signed [CW-1:0]  cx1_r, cy1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dxa1_r <= DFW'(ax) - DFW'(cx);
      dya1_r <= DFW'(ay) - DFW'(cy);
      dxb1_r <= DFW'(bx) - DFW'(cx);
      dyb1_r <= DFW'(by_coord) - DFW'(cy);
      cx1_r  <= cx;
      cy1_r  <= cy;
    end
  end

  // stage 2: determinant products and squares
  logic signed [PW-1:0]  pd1_2_r, pd2_2_r;
  logic [SQW-1:0]        sxa2_r, sya2_r, sxb2_r, syb2_r;
  logic signed [DFW-1:0] dxa2_r, dya2_r, dxb2_r, dyb2_r;
  logic signed [CW-1:0]  cx2_r, cy2_r;
  logic signed [PW-1:0]  sqa_x, sqa_y, sqb_x, sqb_y;

  assign sqa_x = PW'(dxa1_r) * PW'(dxa1_r);
  assign sqa_y = PW'(dya1_r) * PW'(dya1_r);
  assign sqb_x = PW'(dxb1_r) * PW'(dxb1_r);
  assign sqb_y = PW'(dyb1_r) * PW'(dyb1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pd1_2_r <= PW'(dxa1_r) * PW'(dyb1_r);
      pd2_2_r <= PW'(dxb1_r) * PW'(dya1_r);
      sxa2_r  <= sqa_x[SQW-1:0];
      sya2_r  <= sqa_y[SQW-1:0];
      sxb2_r  <= sqb_x[SQW-1:0];
      syb2_r  <= sqb_y[SQW-1:0];
      dxa2_r  <= dxa1_r;
      dya2_r  <= dya1_r;
      dxb2_r  <= dxb1_r;
      dyb2_r  <= dyb1_r;
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;
    end
  end

  // stage 3: determinant and squared edge lengths
  logic signed [DW-1:0]  d3_r;
  logic [LW-1:0]         la3_r, lb3_r;
  logic signed [DFW-1:0] dxa3_r, dya3_r, dxb3_r, dyb3_r;
  logic signed [CW-1:0]  cx3_r, cy3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r   <= DW'(pd1_2_r) - DW'(pd2_2_r);
      la3_r  <= LW'(sxa2_r) + LW'(sya2_r);
      lb3_r  <= LW'(sxb2_r) + LW'(syb2_r);
      dxa3_r <= dxa2_r;
      dya3_r <= dya2_r;
      dxb3_r <= dxb2_r;
      dyb3_r <= dyb2_r;
      cx3_r  <= cx2_r;
      cy3_r  <= cy2_r;
    end
  end

  // stage 4: split partial products, orientation clip
  logic signed [PPW-1:0] pa_lo4_r, pa_hi4_r, pb_lo4_r, pb_hi4_r;
  logic signed [PPW-1:0] pc_lo4_r, pc_hi4_r, pe_lo4_r, pe_hi4_r;
  logic signed [DW-1:0]  d4_r;
  logic signed [CW-1:0]  cx4_r, cy4_r;
  logic [ORIENT_W-1:0]   or4_r;
  logic                  deg4_r;
  logic signed [PPW-1:0] la_lo, la_hi, lb_lo, lb_hi;
  logic signed [EW-1:0]  d_e;
  logic signed [EW-1:0]  d_c;

  assign la_lo = PPW'({1'b0, la3_r[LH-1:0]});
  assign la_hi = PPW'({1'b0, la3_r[LW-1:LH]});
  assign lb_lo = PPW'({1'b0, lb3_r[LH-1:0]});
  assign lb_hi = PPW'({1'b0, lb3_r[LW-1:LH]});
  assign d_e   = EW'(d3_r);
  assign d_c   = (d_e > OMAX) ? OMAX : ((d_e < OMIN) ? OMIN : d_e);

  always_ff @(posedge clk) begin
    if (en) begin
      pa_lo4_r <= PPW'(dyb3_r) * la_lo;
      pa_hi4_r <= PPW'(dyb3_r) * la_hi;
      pb_lo4_r <= PPW'(dya3_r) * lb_lo;
      pb_hi4_r <= PPW'(dya3_r) * lb_hi;
      pc_lo4_r <= PPW'(dxa3_r) * lb_lo;
      pc_hi4_r <= PPW'(dxa3_r) * lb_hi;
      pe_lo4_r <= PPW'(dxb3_r) * la_lo;
      pe_hi4_r <= PPW'(dxb3_r) * la_hi;
      d4_r     <= d3_r;
      cx4_r    <= cx3_r;
      cy4_r    <= cy3_r;
      or4_r    <= d_c[ORIENT_W-1:0];
      deg4_r   <= (d3_r == '0);
    end
  end

  // stage 5: join partial products
  logic signed [PAW-1:0] pa5_r, pb5_r, pc5_r, pe5_r;
  logic signed [DW-1:0]  d5_r;
  logic signed [CW-1:0]  cx5_r, cy5_r;
  logic [ORIENT_W-1:0]   or5_r;
  logic                  deg5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa5_r  <= (PAW'(pa_hi4_r) <<< LH) + PAW'(pa_lo4_r);
      pb5_r  <= (PAW'(pb_hi4_r) <<< LH) + PAW'(pb_lo4_r);
      pc5_r  <= (PAW'(pc_hi4_r) <<< LH) + PAW'(pc_lo4_r);
      pe5_r  <= (PAW'(pe_hi4_r) <<< LH) + PAW'(pe_lo4_r);
      d5_r   <= d4_r;
      cx5_r  <= cx4_r;
      cy5_r  <= cy4_r;
      or5_r  <= or4_r;
      deg5_r <= deg4_r;
    end
  end

  // stage 6: center offset numerators, divisor
  logic signed [UW-1:0] ux6_r, uy6_r;
  logic [DW-1:0]        den6_r;
  logic                 dneg6_r;
  logic signed [CW-1:0] cx6_r, cy6_r;
  logic [ORIENT_W-1:0]  or6_r;
  logic                 deg6_r;
  logic [DW-1:0]        d_abs;

  assign d_abs = d5_r[DW-1] ? DW'(-d5_r) : DW'(d5_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ux6_r   <= UW'(pa5_r) - UW'(pb5_r);
      uy6_r   <= UW'(pc5_r) - UW'(pe5_r);
      den6_r  <= {d_abs[DW-2:0], 1'b0};
      dneg6_r <= d5_r[DW-1];
      cx6_r   <= cx5_r;
      cy6_r   <= cy5_r;
      or6_r   <= or5_r;
      deg6_r  <= deg5_r;
    end
  end

  // stage 7: magnitudes scaled to fixed point
  logic [NW-1:0] numx7_r, numy7_r;
  logic [DW-1:0] den7_r;
  side_t         side7_r;
  logic [UW-1:0] ux_mag, uy_mag;

  assign ux_mag = ux6_r[UW-1] ? UW'(-ux6_r) : UW'(ux6_r);
  assign uy_mag = uy6_r[UW-1] ? UW'(-uy6_r) : UW'(uy6_r);

  always_ff @(posedge clk) begin
    if (en) begin
      numx7_r        <= NW'(ux_mag) << FRAC_BITS;
      numy7_r        <= NW'(uy_mag) << FRAC_BITS;
      den7_r         <= den6_r;
      side7_r.cx     <= cx6_r;
      side7_r.cy     <= cy6_r;
      side7_r.negx   <= ux6_r[UW-1] ^ dneg6_r;
      side7_r.negy   <= uy6_r[UW-1] ^ dneg6_r;
      side7_r.orient <= or6_r;
      side7_r.deg    <= deg6_r;
    end
  end

  // division
  logic [QUOT_BITS:0] qx, qy;
  logic               ovfx, ovfy;

  ccirc_div #(.NUM_W(NW), .DEN_W(DW)) u_div_x (
    .clk (clk), .en (en), .num (numx7_r), .den (den7_r), .quot (qx), .ovf (ovfx)
  );

  ccirc_div #(.NUM_W(NW), .DEN_W(DW)) u_div_y (
    .clk (clk), .en (en), .num (numy7_r), .den (den7_r), .quot (qy), .ovf (ovfy)
  );

  side_t sd_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side7_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  // p1: place center, square offsets
  side_t                sd;
  logic signed [VW-1:0] vx1_r, vy1_r;
  logic                 bigx1_r, bigy1_r, negx1_r, negy1_r, radbig1_r, deg1_r;
  logic [ORIENT_W-1:0]  or1_r;
  logic [2*OUT_W-1:0]   sx1_r, sy1_r;
  logic signed [VW-1:0] offx, offy, basex, basey;

  assign sd    = sd_r[DIV_LAT-1];
  assign offx  = VW'(qx[QUOT_BITS-2:0]);
  assign offy  = VW'(qy[QUOT_BITS-2:0]);
  assign basex = VW'(sd.cx) <<< FRAC_BITS;
  assign basey = VW'(sd.cy) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      vx1_r     <= sd.negx ? (basex - offx) : (basex + offx);
      vy1_r     <= sd.negy ? (basey - offy) : (basey + offy);
      bigx1_r   <= ovfx || (|qx[QUOT_BITS -: 2]);
      bigy1_r   <= ovfy || (|qy[QUOT_BITS -: 2]);
      negx1_r   <= sd.negx;
      negy1_r   <= sd.negy;
      radbig1_r <= ovfx || ovfy || (|qx[QUOT_BITS:OUT_W]) || (|qy[QUOT_BITS:OUT_W]);
      sx1_r     <= (2*OUT_W)'(qx[OUT_W-1:0]) * (2*OUT_W)'(qx[OUT_W-1:0]);
      sy1_r     <= (2*OUT_W)'(qy[OUT_W-1:0]) * (2*OUT_W)'(qy[OUT_W-1:0]);
      or1_r     <= sd.orient;
      deg1_r    <= sd.deg;
    end
  end

  // p2: clip center, sum of squares
  tail_t                tail2_r;
  logic [2*OUT_W-1:0]   sq2_r;
  logic [2*OUT_W:0]     ssum;
  logic signed [VW-1:0] clx, cly;
  logic                 satx, saty;

  assign ssum = (2*OUT_W+1)'(sx1_r) + (2*OUT_W+1)'(sy1_r);

  always_comb begin
    satx = 1'b1;
    saty = 1'b1;
    priority if (bigx1_r) clx = negx1_r ? CMIN : CMAX;
    else if (vx1_r > CMAX) clx = CMAX;
    else if (vx1_r < CMIN) clx = CMIN;
    else begin
      clx  = vx1_r;
      satx = 1'b0;
    end
    priority if (bigy1_r) cly = negy1_r ? CMIN : CMAX;
    else if (vy1_r > CMAX) cly = CMAX;
    else if (vy1_r < CMIN) cly = CMIN;
    else begin
      cly  = vy1_r;
      saty = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail2_r.ctr_x  <= clx[OUT_W-1:0];
      tail2_r.ctr_y  <= cly[OUT_W-1:0];
      tail2_r.csat   <= satx || saty;
      tail2_r.rsat   <= radbig1_r || ssum[2*OUT_W];
      tail2_r.orient <= or1_r;
      tail2_r.deg    <= deg1_r;
      sq2_r          <= ssum[2*OUT_W-1:0];
    end
  end

  // square root
  logic [ROOT_W-1:0] root;

  ccirc_isqrt u_isqrt (
    .clk (clk), .en (en), .sq (sq2_r), .root (root)
  );

  tail_t tl_r [SQ_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      tl_r[0] <= tail2_r;
      for (int i = 1; i < SQ_LAT; i++) begin
        tl_r[i] <= tl_r[i-1];
      end
    end
  end

  // output register
  tail_t            tl;
  logic [OUT_W-1:0] ocx_r, ocy_r, orad_r;
  logic [ORIENT_W-1:0] oor_r;
  logic             odeg_r, osat_r;

  assign tl = tl_r[SQ_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      oor_r  <= tl.orient;
      odeg_r <= tl.deg;
      if (tl.deg) begin
        ocx_r  <= '0;
        ocy_r  <= '0;
        orad_r <= '0;
        osat_r <= 1'b0;
      end else begin
        ocx_r  <= tl.ctr_x;
        ocy_r  <= tl.ctr_y;
        orad_r <= tl.rsat ? '1 : OUT_W'(root);
        osat_r <= tl.csat || tl.rsat;
      end
    end
  end

  assign out_tdata = OUT_DATA_W'({oor_r, orad_r, ocy_r, ocx_r});
  assign out_tuser = {osat_r, odeg_r};

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_DEG] |-> out_tdata[3*OUT_W-1:0] == '0 && !out_tuser[USER_SAT])
    else $error("degenerate beat with nonzero center, radius or saturation");

  a_deg_orient: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[3*OUT_W +: ORIENT_W] == '0) == out_tuser[USER_DEG]))
    else $error("degenerate flag disagrees with orientation");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a stalled result beat");

endmodule

`default_nettype wire
